[hdl/hcirx_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HCI UART receive deframer package
// Shared types and codes for the H4 receive deframer and the credit counter.
// ----------------------------------------------------------------------------
package hcirx_pkg;

    // packet_kind codes
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_EVENT = 2'd1;
    localparam logic [1:0] KIND_ACL   = 2'd2;

    // byte_role codes
    localparam logic [1:0] ROLE_IND   = 2'd0;
    localparam logic [1:0] ROLE_HDR   = 2'd1;
    localparam logic [1:0] ROLE_PAY   = 2'd2;
    localparam logic [1:0] ROLE_NONE  = 2'd3;

    // H4 packet indicators and event codes
    localparam logic [7:0] IND_EVENT        = 8'h04;
    localparam logic [7:0] IND_ACL          = 8'h02;
    localparam logic [7:0] EVT_CMD_COMPLETE = 8'h0E;
    localparam logic [7:0] EVT_CMD_STATUS   = 8'h0F;

    // input mode codes
    localparam logic MODE_RX   = 1'b0;
    localparam logic MODE_SEND = 1'b1;

    localparam logic [7:0] CREDITS_RESET = 8'd1;

    // per-byte labels from the deframer
    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  role;
        logic [7:0]  data;
        logic [15:0] pidx;
        logic        pend;
        logic [7:0]  code;
        logic [15:0] hnd;
        logic [15:0] plen;
        logic        bad;
    } t_frame;

    // credit reload request at the end of a credit-bearing event
    typedef struct packed {
        logic       load;
        logic [7:0] value;
    } t_credit_upd;

    // full result word held in the output register
    typedef struct packed {
        t_frame     frame;
        logic       grant;
        logic [7:0] credits;
    } t_result;

endpackage

[hdl/hcirx_deframer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HCI UART receive deframer
// Walks the H4 byte stream, labels each byte and flags credit-bearing events.
// ----------------------------------------------------------------------------
module hcirx_deframer (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_take,
    input  logic                    i_mode,
    input  logic [7:0]              i_rx_byte,
    output hcirx_pkg::t_frame       o_frame,
    output hcirx_pkg::t_credit_upd  o_upd
);
    import hcirx_pkg::*;

    localparam logic [3:0] PH_IDLE      = 4'd0;
    localparam logic [3:0] PH_EVT_CODE  = 4'd1;
    localparam logic [3:0] PH_EVT_LEN   = 4'd2;
    localparam logic [3:0] PH_EVT_PARAM = 4'd3;
    localparam logic [3:0] PH_ACL_H0    = 4'd4;
    localparam logic [3:0] PH_ACL_H1    = 4'd5;
    localparam logic [3:0] PH_ACL_L0    = 4'd6;
    localparam logic [3:0] PH_ACL_L1    = 4'd7;
    localparam logic [3:0] PH_ACL_DATA  = 4'd8;

    logic [3:0]  r_phase, n_phase;
    logic [15:0] r_left,  n_left;
    logic [15:0] r_pos,   n_pos;
    logic [7:0]  r_code,  n_code;
    logic [7:0]  r_p0,    n_p0;
    logic [7:0]  r_p1,    n_p1;
    logic [15:0] r_hnd,   n_hnd;
    logic [15:0] r_len,   n_len;
    logic        finish;

    always_comb begin
        n_phase = r_phase;
        n_left  = r_left;
        n_pos   = r_pos;
        n_code  = r_code;
        n_p0    = r_p0;
        n_p1    = r_p1;
        n_hnd   = r_hnd;
        n_len   = r_len;
        finish  = 1'b0;
        o_frame = '{kind: KIND_NONE, role: ROLE_NONE, data: 8'h00, pidx: 16'h0000,
                    pend: 1'b0, code: 8'h00, hnd: 16'h0000, plen: 16'h0000,
                    bad: 1'b0};
        if (i_mode == MODE_RX) begin
            o_frame.data = i_rx_byte;
            case (r_phase)
                PH_EVT_CODE: begin
                    n_code       = i_rx_byte;
                    o_frame.kind = KIND_EVENT;
                    o_frame.role = ROLE_HDR;
                    o_frame.code = i_rx_byte;
                    n_phase      = PH_EVT_LEN;
                end
                PH_EVT_LEN: begin
                    n_len        = {8'h00, i_rx_byte};
                    n_left       = {8'h00, i_rx_byte};
                    n_pos        = 16'h0000;
                    o_frame.kind = KIND_EVENT;
                    o_frame.role = ROLE_HDR;
                    o_frame.code = r_code;
                    o_frame.plen = {8'h00, i_rx_byte};
                    if (i_rx_byte == 8'h00) begin
                        o_frame.pend = 1'b1;
                        n_phase      = PH_IDLE;
                    end else begin
                        n_phase      = PH_EVT_PARAM;
                    end
                end
                PH_EVT_PARAM: begin
                    if (r_pos == 16'd0) begin
                        n_p0 = i_rx_byte;
                    end else if (r_pos == 16'd1) begin
                        n_p1 = i_rx_byte;
                    end
                    o_frame.kind = KIND_EVENT;
                    o_frame.role = ROLE_PAY;
                    o_frame.code = r_code;
                    o_frame.plen = r_len;
                    o_frame.pidx = r_pos;
                    n_pos        = r_pos + 16'd1;
                    n_left       = r_left - 16'd1;
                    if (n_left == 16'd0) begin
                        o_frame.pend = 1'b1;
                        finish       = 1'b1;
                        n_phase      = PH_IDLE;
                    end
                end
                PH_ACL_H0: begin
                    n_hnd        = {8'h00, i_rx_byte};
                    o_frame.kind = KIND_ACL;
                    o_frame.role = ROLE_HDR;
                    o_frame.hnd  = n_hnd;
                    n_phase      = PH_ACL_H1;
                end
                PH_ACL_H1: begin
                    n_hnd        = r_hnd | {i_rx_byte, 8'h00};
                    o_frame.kind = KIND_ACL;
                    o_frame.role = ROLE_HDR;
                    o_frame.hnd  = n_hnd;
                    n_phase      = PH_ACL_L0;
                end
                PH_ACL_L0: begin
                    n_len        = {8'h00, i_rx_byte};
                    o_frame.kind = KIND_ACL;
                    o_frame.role = ROLE_HDR;
                    o_frame.hnd  = r_hnd;
                    o_frame.plen = n_len;
                    n_phase      = PH_ACL_L1;
                end
                PH_ACL_L1: begin
                    n_len        = r_len | {i_rx_byte, 8'h00};
                    n_left       = n_len;
                    n_pos        = 16'h0000;
                    o_frame.kind = KIND_ACL;
                    o_frame.role = ROLE_HDR;
                    o_frame.hnd  = r_hnd;
                    o_frame.plen = n_len;
                    if (n_len == 16'd0) begin
                        o_frame.pend = 1'b1;
                        n_phase      = PH_IDLE;
                    end else begin
                        n_phase      = PH_ACL_DATA;
                    end
                end
                PH_ACL_DATA: begin
                    o_frame.kind = KIND_ACL;
                    o_frame.role = ROLE_PAY;
                    o_frame.hnd  = r_hnd;
                    o_frame.plen = r_len;
                    o_frame.pidx = r_pos;
                    n_pos        = r_pos + 16'd1;
                    n_left       = r_left - 16'd1;
                    if (n_left == 16'd0) begin
                        o_frame.pend = 1'b1;
                        n_phase      = PH_IDLE;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                    if (i_rx_byte == IND_EVENT || i_rx_byte == IND_ACL) begin
                        o_frame.role = ROLE_IND;
                        n_code  = 8'h00;
                        n_hnd   = 16'h0000;
                        n_len   = 16'h0000;
                        n_left  = 16'h0000;
                        n_pos   = 16'h0000;
                        n_phase = (i_rx_byte == IND_EVENT) ? PH_EVT_CODE : PH_ACL_H0;
                    end else begin
                        // drop unknown indicator
                        o_frame.bad  = 1'b1;
                        o_frame.data = 8'h00;
                    end
                end
            endcase
        end
    end

    // reload credits from the fresh parameter values at the event's last byte
    always_comb begin
        o_upd = '{load: 1'b0, value: 8'h00};
        if (finish) begin
            if (r_code == EVT_CMD_COMPLETE && r_len >= 16'd1) begin
                o_upd = '{load: 1'b1, value: n_p0};
            end else if (r_code == EVT_CMD_STATUS && r_len >= 16'd2) begin
                o_upd = '{load: 1'b1, value: n_p1};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_left  <= 16'h0000;
            r_pos   <= 16'h0000;
            r_code  <= 8'h00;
            r_p0    <= 8'h00;
            r_p1    <= 8'h00;
            r_hnd   <= 16'h0000;
            r_len   <= 16'h0000;
        end else if (i_take) begin
            r_phase <= n_phase;
            r_left  <= n_left;
            r_pos   <= n_pos;
            r_code  <= n_code;
            r_p0    <= n_p0;
            r_p1    <= n_p1;
            r_hnd   <= n_hnd;
            r_len   <= n_len;
        end
    end

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase <= PH_ACL_DATA)
        else $error("deframer phase out of range");

    a_param_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_EVT_PARAM || r_phase == PH_ACL_DATA) |-> r_left != 16'd0)
        else $error("payload phase with no bytes left");

    a_pos_in_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_EVT_PARAM || r_phase == PH_ACL_DATA) |-> r_pos < r_len)
        else $error("payload position past declared length");

endmodule

[hdl/hcirx_credits.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HCI command credit counter
// Grants send requests against the credit count; reloads from events and cfg.
// ----------------------------------------------------------------------------
module hcirx_credits (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_take,
    input  logic                    i_mode,
    input  hcirx_pkg::t_credit_upd  i_upd,
    input  logic                    i_cfg_we,
    input  logic [7:0]              i_cfg_data,
    output logic                    o_grant,
    output logic [7:0]              o_credits_next
);
    import hcirx_pkg::*;

    logic [7:0] r_credits;

    always_comb begin
        o_grant        = 1'b0;
        o_credits_next = r_credits;
        if (i_mode == MODE_SEND) begin
            if (r_credits != 8'd0) begin
                o_grant        = 1'b1;
                o_credits_next = r_credits - 8'd1;
            end
        end else if (i_upd.load) begin
            o_credits_next = i_upd.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credits <= CREDITS_RESET;
        end else if (i_cfg_we) begin
            r_credits <= i_cfg_data;
        end else if (i_take) begin
            r_credits <= o_credits_next;
        end
    end

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && !i_cfg_we && i_mode == MODE_SEND && r_credits == 8'd0)
        |=> r_credits == 8'd0)
        else $error("denied send changed credits");

    a_grant_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && !i_cfg_we && o_grant) |=> r_credits == $past(r_credits) - 8'd1)
        else $error("granted send did not take one credit");

    a_grant_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_grant |-> (i_mode == MODE_SEND && !i_upd.load))
        else $error("grant outside a send request");

endmodule

[hdl/hci_uart_rx_deframer_with_credits_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HCI UART receive deframer with command credits
// H4 receive deframer and credit gate with a registered result stage.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                 payload
//  in       input      i_in_valid / o_in_stall   i_mode, i_rx_byte
//  out      output     o_out_valid / i_out_stall packet fields, grant, credits
//  cfg      input      i_cfg_we                  i_cfg_data (initial credits)
//
//  One item per cycle while the input is not stalled: each transfer is labelled
//  combinationally and its result enters the output register at the next edge.
//  Reset (synchronous, active low) returns to idle with one credit.
//  A stalled result holds the output register; the input stalls only while
//  a held result is not taken in the same cycle.
// ----------------------------------------------------------------------------
module hci_uart_rx_deframer_with_credits_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_mode,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_packet_kind,
    output logic [1:0]  o_byte_role,
    output logic [7:0]  o_data_byte,
    output logic [15:0] o_payload_index,
    output logic        o_packet_end,
    output logic [7:0]  o_event_code_seen,
    output logic [15:0] o_conn_handle,
    output logic [15:0] o_payload_length,
    output logic        o_bad_indicator,
    output logic        o_send_granted,
    output logic [7:0]  o_credits_now,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_data
);
    import hcirx_pkg::*;

    t_frame      frame;
    t_credit_upd upd;
    logic        grant;
    logic [7:0]  credits_next;
    logic        take;
    logic        r_out_valid;
    t_result     r_out;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign take       = i_in_valid && !o_in_stall;

    hcirx_deframer u_deframer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (take),
        .i_mode    (i_mode),
        .i_rx_byte (i_rx_byte),
        .o_frame   (frame),
        .o_upd     (upd)
    );

    hcirx_credits u_credits (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_take         (take),
        .i_mode         (i_mode),
        .i_upd          (upd),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .o_grant        (grant),
        .o_credits_next (credits_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= '{frame: frame, grant: grant, credits: credits_next};
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_packet_kind     = r_out.frame.kind;
    assign o_byte_role       = r_out.frame.role;
    assign o_data_byte       = r_out.frame.data;
    assign o_payload_index   = r_out.frame.pidx;
    assign o_packet_end      = r_out.frame.pend;
    assign o_event_code_seen = r_out.frame.code;
    assign o_conn_handle     = r_out.frame.hnd;
    assign o_payload_length  = r_out.frame.plen;
    assign o_bad_indicator   = r_out.frame.bad;
    assign o_send_granted    = r_out.grant;
    assign o_credits_now     = r_out.credits;

    a_grant_no_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_send_granted) |->
        (o_byte_role == ROLE_NONE && o_packet_kind == KIND_NONE && !o_packet_end))
        else $error("granted send carries packet fields");

    a_bad_dropped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_bad_indicator) |->
        (o_byte_role == ROLE_NONE && o_data_byte == 8'h00 && !o_send_granted))
        else $error("bad indicator byte was passed on");

    a_end_in_packet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_packet_end) |->
        (o_packet_kind == KIND_EVENT || o_packet_kind == KIND_ACL))
        else $error("packet end outside a packet");

endmodule
